// ----- sv/wlps_pkg.sv -----
// Shared types and constants for the window/level pixel stretch.
`default_nettype none
package wlps_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned BitsW = 5;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 2;
  localparam int unsigned DivW  = 25;
  localparam int unsigned DenW  = 17;

  typedef enum logic [IdxW-1:0] {
    REG_PIXEL_BITS  = 2'd0,
    REG_WINDOW_LOW  = 2'd1,
    REG_WINDOW_HIGH = 2'd2
  } reg_idx_t;

  typedef enum logic [7:0] {
    S_LO      = 8'b0000_0001,
    S_LO_WAIT = 8'b0000_0010,
    S_HI      = 8'b0000_0100,
    S_HI_WAIT = 8'b0000_1000,
    S_ST      = 8'b0001_0000,
    S_ST_WAIT = 8'b0010_0000,
    S_FILL    = 8'b0100_0000,
    S_IDLE    = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic            load;
    logic [DivW-1:0] dividend;
    logic [DenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [PixW-1:0] quot;
    logic [PixW-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- sv/wlps_ram.sv -----
// Generic simple dual-port RAM with a registered read port.
`default_nettype none
module wlps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/wlps_div.sv -----
// Restoring divider, one quotient bit per cycle, for quotients below 256.
`default_nettype none
module wlps_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire wlps_pkg::div_req_t req,
  output wlps_pkg::div_rsp_t      rsp
);
  import wlps_pkg::*;

  logic [DivW-1:0] rem;
  logic [DivW-1:0] den_sh;
  logic [PixW-1:0] quot;
  logic [2:0]      cnt;
  logic            run;
  logic            done;
  logic            fits;

  assign fits = (rem >= den_sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else if (req.load) begin
      // The divisor starts aligned to the top quotient bit.
      rem    <= req.dividend;
      den_sh <= {1'b0, req.divisor, 7'b0};
      quot   <= '0;
      cnt    <= '0;
      run    <= 1'b1;
      done   <= 1'b0;
    end else if (run) begin
      if (fits) begin
        rem <= rem - den_sh;
      end
      quot   <= {quot[PixW-2:0], fits};
      den_sh <= den_sh >> 1;
      cnt    <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem[PixW-1:0];

endmodule
`default_nettype wire

// ----- sv/window_level_pixel_stretch.sv -----
// Window/level contrast stretch of an 8-bit pixel stream through a lookup RAM.
//
//  Channel  | Ports                         | Direction | Request taken when
//  ---------+-------------------------------+-----------+----------------------------
//  command  | start, busy, pixel            | in/out    | start high and busy low
//  result   | done, level, stretched        | out       | every cycle done is high
//  config   | cfg_we, cfg_addr, cfg_data    | in        | every cycle cfg_we is high
//
// Each accepted request gives its result in the next cycle, and one request can be
// accepted in every clock while busy is low: the pixel addresses a 256-entry lookup RAM
// whose registered read data is the result, and done is registered from the acceptance.
// After reset and after every configuration write the RAM is rebuilt while busy is high:
// three serial divisions, then one RAM entry per cycle for all 256 entries. A write
// during a rebuild restarts it. The receiver cannot stall.
`default_nettype none
module window_level_pixel_stretch (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [wlps_pkg::PixW-1:0]     pixel,
  output logic                               done,
  output logic      [wlps_pkg::PixW-1:0]     level,
  output logic                               stretched,
  input  wire logic                          cfg_we,
  input  wire logic [wlps_pkg::IdxW-1:0]     cfg_addr,
  input  wire logic [wlps_pkg::CfgW-1:0]     cfg_data
);
  import wlps_pkg::*;

  // Scaled dividend for round-half-up of v*255/s: v*510 + s, over a divisor of 2*s.
  function automatic logic [DivW-1:0] eighth_dividend(input logic [CfgW-1:0] v,
                                                      input logic [CfgW-1:0] s);
    logic [DivW-1:0] times512;
    logic [DivW-1:0] times2;
    times512 = {v, 9'b0};
    times2   = {8'b0, v, 1'b0};
    return times512 - times2 + {9'b0, s};
  endfunction

  // Configuration registers.
  logic [BitsW-1:0] pixel_bits;
  logic [CfgW-1:0]  window_low;
  logic [CfgW-1:0]  window_high;

  state_t state;

  // Values worked out during a rebuild.
  logic [PixW-1:0] lo8;
  logic [PixW-1:0] hi8;
  logic [PixW-1:0] step_q;
  logic [PixW-1:0] step_r;
  logic            active;

  // Table fill walker: fill_q and fill_r hold (addr-lo8)*255 divided by the span.
  logic [PixW-1:0] fill_addr;
  logic [PixW-1:0] fill_q;
  logic [PixW-1:0] fill_r;
  logic [PixW-1:0] fill_level;
  logic [PixW-1:0] span;
  logic [PixW:0]   sum_r;
  logic            carry;

  logic [CfgW:0]   scale_wide;
  logic [CfgW-1:0] full_scale;
  logic [CfgW-1:0] lo_c;
  logic [CfgW-1:0] hi_c;
  logic            window_open;
  logic            accept;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Full scale of the sensor and the window edges clamped to it.
  assign scale_wide = (17'd1 << pixel_bits) - 17'd1;
  assign full_scale = (pixel_bits >= 5'd1 && pixel_bits <= 5'd16) ? scale_wide[CfgW-1:0]
                                                                 : 16'd255;
  assign lo_c = (window_low  > full_scale) ? full_scale : window_low;
  assign hi_c = (window_high > full_scale) ? full_scale : window_high;

  // A window that is not the full scale and not empty may stretch; the rescaled edges
  // must still differ after rounding.
  assign window_open = ((lo_c != '0) || (hi_c != full_scale)) && (hi_c > lo_c);

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // The shared divider works out lo8, hi8 and then 255 over the span.
  always_comb begin
    div_req.load     = 1'b0;
    div_req.dividend = eighth_dividend(lo_c, full_scale);
    div_req.divisor  = {full_scale, 1'b0};
    case (state)
      S_LO: begin
        div_req.load = 1'b1;
      end
      S_HI: begin
        div_req.load     = 1'b1;
        div_req.dividend = eighth_dividend(hi_c, full_scale);
      end
      S_ST: begin
        div_req.load     = 1'b1;
        div_req.dividend = 25'd255;
        div_req.divisor  = {9'b0, span};
      end
      default: begin
      end
    endcase
  end

  wlps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Each table step adds 255 to the numerator: quotient and remainder grow by the
  // precomputed 255/span, with one correction when the remainder reaches the span.
  assign span  = hi8 - lo8;
  assign sum_r = {1'b0, fill_r} + {1'b0, step_r};
  assign carry = (sum_r >= {1'b0, span});

  always_comb begin
    if (!active) begin
      fill_level = fill_addr;
    end else if (fill_addr <= lo8) begin
      fill_level = '0;
    end else if (fill_addr >= hi8) begin
      fill_level = 8'd255;
    end else begin
      fill_level = fill_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_bits  <= 5'd8;
      window_low  <= 16'd0;
      window_high <= 16'd255;
      state       <= S_LO;
      active      <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= accept;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_PIXEL_BITS:  pixel_bits  <= cfg_data[BitsW-1:0];
          REG_WINDOW_LOW:  window_low  <= cfg_data;
          REG_WINDOW_HIGH: window_high <= cfg_data;
          default: begin
          end
        endcase
        state <= S_LO;
      end else begin
        unique case (state)
          S_LO:      state <= S_LO_WAIT;
          S_LO_WAIT: begin
            if (div_rsp.done) begin
              lo8   <= div_rsp.quot;
              state <= S_HI;
            end
          end
          S_HI:      state <= S_HI_WAIT;
          S_HI_WAIT: begin
            if (div_rsp.done) begin
              hi8   <= div_rsp.quot;
              state <= S_ST;
            end
          end
          S_ST: begin
            active <= window_open && (hi8 > lo8);
            state  <= S_ST_WAIT;
          end
          S_ST_WAIT: begin
            if (div_rsp.done) begin
              step_q    <= div_rsp.quot;
              step_r    <= div_rsp.rem;
              fill_addr <= '0;
              fill_q    <= '0;
              fill_r    <= '0;
              state     <= S_FILL;
            end
          end
          S_FILL: begin
            if (fill_addr >= lo8) begin
              if (carry) begin
                fill_q <= fill_q + step_q + 8'd1;
                fill_r <= 8'(sum_r - {1'b0, span});
              end else begin
                fill_q <= fill_q + step_q;
                fill_r <= sum_r[PixW-1:0];
              end
            end
            fill_addr <= fill_addr + 8'd1;
            if (fill_addr == 8'hFF) begin
              state <= S_IDLE;
            end
          end
          S_IDLE:    state <= S_IDLE;
          default:   state <= S_LO;
        endcase
      end
    end
  end

  wlps_ram #(
    .Width (PixW),
    .Depth (256)
  ) u_lut (
    .clk   (clk),
    .we    (state == S_FILL),
    .waddr (fill_addr),
    .wdata (fill_level),
    .re    (accept),
    .raddr (pixel),
    .rdata (level)
  );

  assign stretched = active;

  // A result appears only in the cycle after an accepted request.
  a_done_follows_accept : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result strobe without an accepted request");

  // Any configuration write starts a rebuild, so no request is taken right after it.
  a_write_rebuilds : assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> busy)
    else $error("configuration write did not start a table rebuild");

  // The stretch flag can only be set when the rescaled edges are ordered.
  a_stretch_ordered : assert property (@(posedge clk) disable iff (rst)
    (!busy && stretched) |-> (hi8 > lo8))
    else $error("stretch active with an empty rescaled window");

  // The fill walks every table entry in order unless a write restarts it.
  a_fill_walks : assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && fill_addr != 8'hFF && !cfg_we)
      |=> (state == S_FILL && fill_addr == 8'($past(fill_addr) + 8'd1)))
    else $error("table fill skipped or left early");

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the window/level pixel stretch block.
module tb_top;
  import wlps_pkg::*;

  // Requests accepted back to back may hide a stall while the lookup RAM is rebuilt
  // after configuration. A run of HangLimit cycles with no request taken and no result
  // seen happens only when the block has hung.
  localparam int unsigned HangLimit  = 4000;
  localparam int unsigned RandPixels = 1350;
  // Requests from this count on go out with no idle cycles at all.
  localparam int unsigned CalmTail   = 1200;
  localparam int unsigned NumDirected = 25;

  // Index 3 is not a register; writes to it must leave the mapping untouched.
  localparam logic [IdxW-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [PixW-1:0] level;
    logic            stretched;
  } grey_out_t;

  typedef struct packed {
    logic [BitsW-1:0] bits;
    logic [CfgW-1:0]  wlo;
    logic [CfgW-1:0]  whi;
    logic [PixW-1:0]  pix;
    logic             typed;
    logic [PixW-1:0]  level;
    logic             stretched;
  } stretch_case_t;

  // Directed cases. Where the outcome is obvious (identity windows, pixels beyond the
  // edges) it is written down; the remaining rows are checked against the predictor.
  localparam stretch_case_t DirectedCases [NumDirected] = '{
    // Reset setting: the window covers the full 8-bit scale, so the identity is used.
    '{5'd8,  16'd0,     16'd255,   8'h00, 1'b1, 8'h00, 1'b0},
    '{5'd8,  16'd0,     16'd255,   8'hFF, 1'b1, 8'hFF, 1'b0},
    '{5'd8,  16'd0,     16'd255,   8'hA5, 1'b1, 8'hA5, 1'b0},
    // A plain 64..192 window: edges, beyond the edges, and the slope in between.
    '{5'd8,  16'd64,    16'd192,   8'd64,  1'b1, 8'd0,   1'b1},
    '{5'd8,  16'd64,    16'd192,   8'd63,  1'b1, 8'd0,   1'b1},
    '{5'd8,  16'd64,    16'd192,   8'd192, 1'b1, 8'd255, 1'b1},
    '{5'd8,  16'd64,    16'd192,   8'd255, 1'b1, 8'd255, 1'b1},
    '{5'd8,  16'd64,    16'd192,   8'd128, 1'b0, 8'd0,   1'b0},
    '{5'd8,  16'd64,    16'd192,   8'd65,  1'b0, 8'd0,   1'b0},
    // Empty and inverted windows fall back to the identity.
    '{5'd8,  16'd100,   16'd100,   8'd77,  1'b1, 8'd77,  1'b0},
    '{5'd8,  16'd200,   16'd50,    8'd200, 1'b1, 8'd200, 1'b0},
    // 16-bit sensor: full window, a window just wide enough to survive rescaling,
    // and one that collapses to a single 8-bit level.
    '{5'd16, 16'd0,     16'd65535, 8'd3,   1'b1, 8'd3,   1'b0},
    '{5'd16, 16'd0,     16'd300,   8'd0,   1'b1, 8'd0,   1'b1},
    '{5'd16, 16'd0,     16'd300,   8'd1,   1'b1, 8'd255, 1'b1},
    '{5'd16, 16'd10,    16'd20,    8'd9,   1'b1, 8'd9,   1'b0},
    // One-bit sensor: only full or degenerate windows exist.
    '{5'd1,  16'd0,     16'd1,     8'd1,   1'b1, 8'd1,   1'b0},
    '{5'd1,  16'd1,     16'd0,     8'd0,   1'b1, 8'd0,   1'b0},
    // Depth zero means an 8-bit scale; the high edge is clamped to it.
    '{5'd0,  16'd10,    16'd9999,  8'd10,  1'b1, 8'd0,   1'b1},
    '{5'd0,  16'd10,    16'd9999,  8'd254, 1'b0, 8'd0,   1'b0},
    // Depth 31 also means 8 bits; both edges clamp to full scale and the window is empty.
    '{5'd31, 16'd300,   16'd1000,  8'd17,  1'b1, 8'd17,  1'b0},
    '{5'd17, 16'd0,     16'd128,   8'd200, 1'b1, 8'd255, 1'b1},
    // Two-bit sensor: edges 1 and 2 rescale to 85 and 170.
    '{5'd2,  16'd1,     16'd2,     8'd85,  1'b1, 8'd0,   1'b1},
    '{5'd2,  16'd1,     16'd2,     8'd170, 1'b1, 8'd255, 1'b1},
    '{5'd2,  16'd1,     16'd2,     8'd128, 1'b0, 8'd0,   1'b0},
    // Both edges at the top of a 16-bit scale: empty window.
    '{5'd16, 16'd65535, 16'd65535, 8'h5A,  1'b1, 8'h5A,  1'b0}
  };

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  logic [PixW-1:0] pixel;
  logic            done;
  logic [PixW-1:0] level;
  logic            stretched;
  logic            cfg_we;
  logic [IdxW-1:0] cfg_addr;
  logic [CfgW-1:0] cfg_data;

  // Shadow copy of the block's registers, updated as they are written.
  logic [BitsW-1:0] depth_bits;
  logic [CfgW-1:0]  edge_lo;
  logic [CfgW-1:0]  edge_hi;

  // Expected output levels, oldest first.
  grey_out_t   pending_levels[$];
  // A level written down in the directed table overrides the predictor for one request.
  logic        typed_on;
  grey_out_t   typed_level;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  window_level_pixel_stretch u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .done      (done),
    .level     (level),
    .stretched (stretched),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sensor full scale: 2^bits-1 for depths 1..16, an 8-bit scale otherwise.
  function automatic int unsigned sensor_scale(input logic [BitsW-1:0] bits);
    if (bits >= 1 && bits <= 16) return (32'd1 << bits) - 1;
    return 255;
  endfunction

  // Clamp a window edge to full scale and round it half-up onto the 8-bit axis.
  function automatic int unsigned edge_to_grey(input int unsigned v, input int unsigned s);
    int unsigned c;
    c = (v > s) ? s : v;
    return (2 * c * 255 + s) / (2 * s);
  endfunction

  function automatic grey_out_t stretch_pixel(input logic [PixW-1:0] p,
                                              input logic [BitsW-1:0] bits,
                                              input logic [CfgW-1:0] wlo,
                                              input logic [CfgW-1:0] whi);
    int unsigned s, lo, hi, lo8, hi8;
    grey_out_t   r;
    s = sensor_scale(bits);
    lo = (wlo > s) ? s : wlo;
    hi = (whi > s) ? s : whi;
    r.level = p;
    r.stretched = 1'b0;
    // A full window, or one that is empty before or after rescaling, keeps the identity.
    if ((lo > 0 || hi < s) && hi > lo) begin
      lo8 = edge_to_grey(lo, s);
      hi8 = edge_to_grey(hi, s);
      if (hi8 > lo8) begin
        r.stretched = 1'b1;
        if (p <= lo8) r.level = 8'd0;
        else if (p >= hi8) r.level = 8'd255;
        else r.level = PixW'((p - lo8) * 255 / (hi8 - lo8));
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Results are taken at every rising edge with done high; a request is taken when start
  // is high and busy is low. Both are sampled before the block's registers update, so the
  // values seen here are the ones that were on the ports during the cycle that just ended.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_levels.size() == 0) begin
          report_mismatch($sformatf("result level %0d stretched %0d with no request open",
                                    level, stretched));
        end else begin
          grey_out_t want;
          want = pending_levels.pop_front();
          if (level !== want.level)
            report_mismatch($sformatf("level %0d, expected %0d", level, want.level));
          if (stretched !== want.stretched)
            report_mismatch($sformatf("stretched %0d, expected %0d",
                                      stretched, want.stretched));
        end
      end
      if (start && !busy) begin
        pending_levels.push_back(typed_on ? typed_level :
                                 stretch_pixel(pixel, depth_bits, edge_lo, edge_hi));
      end
    end
    // Hang detection: any cycle that moves a request or a result restarts the count.
    if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HangLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Called at a falling edge. Holds the request until the block takes it, then leaves
  // start low for the given number of idle cycles; with no idle cycles start stays high
  // and the next call simply puts up a new pixel.
  task automatic issue_pixel(input logic [PixW-1:0] p, input logic typed,
                             input grey_out_t want, input int unsigned gap);
    typed_on = typed;
    typed_level = want;
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      pixel <= PixW'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Lowers start and waits until every result of the requests already taken is back.
  // Each request gives exactly one result, so the block is idle at that point.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  // Writes all three registers, plus a stray write to the unused index. The depth
  // register is five bits wide, so the upper bits of its write carry noise.
  task automatic program_window(input logic [BitsW-1:0] bits,
                                input logic [CfgW-1:0] wlo, input logic [CfgW-1:0] whi);
    logic [CfgW-BitsW-1:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? '1 : (CfgW-BitsW)'($urandom);
    write_reg(REG_SPARE, CfgW'($urandom));
    write_reg(REG_PIXEL_BITS, {junk, bits});
    write_reg(REG_WINDOW_LOW, wlo);
    write_reg(REG_WINDOW_HIGH, whi);
    cfg_we <= 1'b0;
    depth_bits = bits;
    edge_lo = wlo;
    edge_hi = whi;
  endtask

  // Pick a random window setting: mostly well-formed windows inside the scale, with
  // full, inverted, out-of-range and one-sided windows mixed in.
  task automatic pick_window(output logic [BitsW-1:0] bits, output logic [CfgW-1:0] wlo,
                             output logic [CfgW-1:0] whi);
    int unsigned s, a, b;
    case ($urandom_range(0, 5))
      0: bits = 5'd8;
      1: bits = 5'd16;
      2: bits = BitsW'($urandom_range(1, 16));
      3: bits = BitsW'($urandom_range(0, 31));
      4: bits = 5'd12;
      default: bits = BitsW'($urandom_range(9, 16));
    endcase
    s = sensor_scale(bits);
    a = $urandom_range(0, s);
    b = $urandom_range(0, s);
    case ($urandom_range(0, 9))
      0: begin
        wlo = CfgW'($urandom);
        whi = CfgW'($urandom);
      end
      1: begin
        wlo = '0;
        whi = CfgW'(s);
      end
      2: begin
        wlo = CfgW'((a > b) ? a : b);
        whi = CfgW'((a > b) ? b : a);
      end
      3: begin
        wlo = '0;
        whi = CfgW'(a);
      end
      4: begin
        wlo = CfgW'(a);
        whi = '1;
      end
      default: begin
        wlo = CfgW'((a < b) ? a : b);
        whi = CfgW'((a < b) ? b : a);
      end
    endcase
  endtask

  initial begin
    logic [BitsW-1:0] bits;
    logic [CfgW-1:0]  wlo, whi;
    logic [PixW-1:0]  p;
    int unsigned      pixels_sent, burst_len, gap, s, lo8, hi8, e;
    logic             calm;
    stretch_case_t    row;

    rst = 1'b1;
    start = 1'b0;
    pixel = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    depth_bits = 5'd8;
    edge_lo = 16'd0;
    edge_hi = 16'd255;
    typed_on = 1'b0;
    typed_level = '0;
    mismatches = 0;
    quiet_cycles = 0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: the registers change only between requests, after the block has
    // answered everything it has taken.
    foreach (DirectedCases[i]) begin
      row = DirectedCases[i];
      if (row.bits != depth_bits || row.wlo != edge_lo || row.whi != edge_hi) begin
        drain_results();
        program_window(row.bits, row.wlo, row.whi);
      end
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
      issue_pixel(row.pix, row.typed, '{row.level, row.stretched}, gap);
    end

    // Random part: phases of one window setting each. A third of the phases run without
    // idle cycles, and the tail of the run has none at all.
    pixels_sent = 0;
    while (pixels_sent < RandPixels) begin
      drain_results();
      pick_window(bits, wlo, whi);
      program_window(bits, wlo, whi);
      s = sensor_scale(bits);
      lo8 = edge_to_grey(wlo, s);
      hi8 = edge_to_grey(whi, s);
      calm = ($urandom_range(0, 2) == 0);
      burst_len = $urandom_range(20, 80);
      repeat (burst_len) begin
        // Half of the pixels land on or next to an edge of the window.
        if ($urandom_range(0, 1) == 0) begin
          p = PixW'($urandom);
        end else begin
          e = ($urandom_range(0, 1) == 0) ? lo8 : hi8;
          e = e + $urandom_range(0, 4);
          e = (e < 2) ? 0 : (e - 2 > 255) ? 255 : e - 2;
          p = PixW'(e);
        end
        if (calm || pixels_sent >= CalmTail || $urandom_range(0, 3) != 0) gap = 0;
        else gap = $urandom_range(1, 17);
        issue_pixel(p, 1'b0, '0, gap);
        pixels_sent++;
      end
    end

    // Let every result come back, then keep watching for stray strobes.
    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- window_level_pixel_stretch.f -----
sv/wlps_pkg.sv
sv/wlps_ram.sv
sv/wlps_div.sv
sv/window_level_pixel_stretch.sv
test/tb_top.sv
